FILE: sv/tnef_pkg.sv
// Package for the tuned note event to frequency block.
// Holds command codes, the queued command type and the constant tables.
// Depends on nothing; every other file of the block but the checker uses it.
`default_nettype none

package tnef_pkg;

    localparam int MANT_W = 30;
    localparam int FREQ_W = 30;
    localparam int STEPS  = 30;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 30'h3FFF_FFFF;

    localparam logic [2:0] REQ_NOP  = 3'd0;
    localparam logic [2:0] REQ_OFF  = 3'd1;
    localparam logic [2:0] REQ_ON53 = 3'd2;
    localparam logic [2:0] REQ_ONJI = 3'd3;
    localparam logic [2:0] REQ_ON31 = 3'd4;

    localparam logic [1:0] OP_OFF  = 2'd0;
    localparam logic [1:0] OP_ON53 = 2'd1;
    localparam logic [1:0] OP_ONJI = 2'd2;
    localparam logic [1:0] OP_ON31 = 2'd3;

    localparam logic ACT_OFF = 1'b0;
    localparam logic ACT_ON  = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] voice;
        logic [3:0] octave;
        logic [5:0] degree;
    } note_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef logic [STEPS-1:0][MANT_W:0] root_tab_t;
    typedef logic [63:0][MANT_W-1:0]    frac_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        int          k;
        rem   = v;
        res   = '0;
        bit_w = 64'd1 << 62;
        for (k = 0; k < 32; k++)
        begin
            if (rem >= res + bit_w)
            begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
            begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Entry k holds 2^(2^-(k+1)) in Q30.
    function automatic root_tab_t make_roots();
        root_tab_t   t;
        logic [63:0] c;
        int          i;
        c = isqrt64(64'd1 << 61);
        for (i = 0; i < STEPS; i++)
        begin
            t[i] = c[MANT_W:0];
            c    = isqrt64(c << MANT_W);
        end
        return t;
    endfunction

    function automatic frac_tab_t make_frac53();
        frac_tab_t   t;
        logic [63:0] x;
        int          r;
        for (r = 0; r < 64; r++)
        begin
            x    = (64'(r) << MANT_W) / 64'd53;
            t[r] = (r < 53) ? x[MANT_W-1:0] : '0;
        end
        return t;
    endfunction

    function automatic frac_tab_t make_frac31();
        frac_tab_t   t;
        logic [63:0] x;
        int          r;
        for (r = 0; r < 64; r++)
        begin
            x    = (64'(r) << MANT_W) / 64'd31;
            t[r] = (r < 31) ? x[MANT_W-1:0] : '0;
        end
        return t;
    endfunction

    localparam root_tab_t EXP_ROOTS = make_roots();
    localparam frac_tab_t FRAC53    = make_frac53();
    localparam frac_tab_t FRAC31    = make_frac31();

    // Returns {hit, mantissa} for the 53-EDO degrees that have a just ratio.
    function automatic logic [MANT_W+1:0] ratio_lookup(input logic [5:0] deg);
        logic [63:0] q;
        logic        hit;
        hit = 1'b1;
        case (deg)
            6'd0:  q = 64'd1 << MANT_W;
            6'd7:  q = ((64'd35 << MANT_W) + 64'd16) / 64'd32;
            6'd8:  q = ((64'd10 << MANT_W) + 64'd4) / 64'd9;
            6'd9:  q = ((64'd9 << MANT_W) + 64'd4) / 64'd8;
            6'd14: q = ((64'd6 << MANT_W) + 64'd2) / 64'd5;
            6'd17: q = ((64'd5 << MANT_W) + 64'd2) / 64'd4;
            6'd18: q = ((64'd80 << MANT_W) + 64'd31) / 64'd63;
            6'd21: q = ((64'd21 << MANT_W) + 64'd8) / 64'd16;
            6'd22: q = ((64'd4 << MANT_W) + 64'd1) / 64'd3;
            6'd24: q = ((64'd11 << MANT_W) + 64'd4) / 64'd8;
            6'd25: q = ((64'd25 << MANT_W) + 64'd9) / 64'd18;
            6'd26: q = ((64'd45 << MANT_W) + 64'd16) / 64'd32;
            6'd29: q = ((64'd35 << MANT_W) + 64'd12) / 64'd24;
            6'd31: q = ((64'd3 << MANT_W) + 64'd1) / 64'd2;
            6'd34: q = ((64'd25 << MANT_W) + 64'd8) / 64'd16;
            6'd36: q = ((64'd8 << MANT_W) + 64'd2) / 64'd5;
            6'd37: q = ((64'd13 << MANT_W) + 64'd4) / 64'd8;
            6'd39: q = ((64'd5 << MANT_W) + 64'd1) / 64'd3;
            6'd40: q = ((64'd27 << MANT_W) + 64'd8) / 64'd16;
            6'd43: q = ((64'd7 << MANT_W) + 64'd2) / 64'd4;
            6'd44: q = ((64'd16 << MANT_W) + 64'd4) / 64'd9;
            6'd45: q = ((64'd9 << MANT_W) + 64'd2) / 64'd5;
            6'd48: q = ((64'd15 << MANT_W) + 64'd4) / 64'd8;
            6'd49: q = ((64'd40 << MANT_W) + 64'd10) / 64'd21;
            default:
            begin
                q   = '0;
                hit = 1'b0;
            end
        endcase
        return {hit, q[MANT_W:0]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/tuned_note_event_to_frequency.sv
// Top level of the tuned note event to frequency block.
// Instantiates tnef_front, tnef_queue and tnef_back; uses tnef_pkg.
//
//   Channel   Handshake                     Payload
//   event     start in, busy out            req_type, track, octave, degree
//   result    result_valid out (one cycle)  action, voice, frequency, last
//
// An event is taken in any cycle the two-entry queue has room; busy means the queue is full.
// A note-off is emitted from the back end's idle state; with the back end idle its result is on
// the ports once it has passed the queue registers and then the output registers.
// A 53-EDO note-on with a just ratio goes from the note-off in the idle state to the note-on.
// Other note-ons run the note-off, 30 steps of the shared exp2/divide sequencer, then the note-on.
// Reset clears the queue and the sequencer; no clearing pass is needed.
// Results cannot be held off by the receiver.
`default_nettype none

module tuned_note_event_to_frequency #(
    parameter int TRACKS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  req_type,
    input  wire logic [3:0]                  track,
    input  wire logic [3:0]                  octave,
    input  wire logic [5:0]                  degree,
    output logic                             result_valid,
    output logic                             action,
    output logic [3:0]                       voice,
    output logic [tnef_pkg::FREQ_W-1:0]      frequency,
    output logic                             last
);

    tnef_pkg::queue_status_t status;
    tnef_pkg::note_cmd_t     push_cmd;
    tnef_pkg::note_cmd_t     pop_cmd;
    logic                    push;
    logic                    pop;

    tnef_front #(
        .TRACKS(TRACKS)
    ) u_front (
        .start   (start),
        .req_type(req_type),
        .track   (track),
        .octave  (octave),
        .degree  (degree),
        .status  (status),
        .busy    (busy),
        .push    (push),
        .push_cmd(push_cmd)
    );

    tnef_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .status  (status)
    );

    tnef_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .status      (status),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .result_valid(result_valid),
        .action      (action),
        .voice       (voice),
        .frequency   (frequency),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: sv/tnef_front.sv
// Front end: takes note events on the start/busy handshake and classifies them.
// Events that cause a result become queued commands. Uses tnef_pkg.
`default_nettype none

module tnef_front #(
    parameter int TRACKS = 16
) (
    input  wire logic                    start,
    input  wire logic [2:0]              req_type,
    input  wire logic [3:0]              track,
    input  wire logic [3:0]              octave,
    input  wire logic [5:0]              degree,
    input  wire tnef_pkg::queue_status_t status,
    output logic                         busy,
    output logic                         push,
    output tnef_pkg::note_cmd_t          push_cmd
);

    localparam logic [6:0] TRACK_LIM = 7'(TRACKS);

    logic       known;
    logic [1:0] op;
    logic       in_range;

    always_comb
    begin
        known = 1'b1;
        unique case (req_type)
            tnef_pkg::REQ_OFF:  op = tnef_pkg::OP_OFF;
            tnef_pkg::REQ_ON53: op = tnef_pkg::OP_ON53;
            tnef_pkg::REQ_ONJI: op = tnef_pkg::OP_ONJI;
            tnef_pkg::REQ_ON31: op = tnef_pkg::OP_ON31;
            default:
            begin
                op    = tnef_pkg::OP_OFF;
                known = 1'b0;
            end
        endcase
    end

    assign in_range = {3'b000, track} < TRACK_LIM;
    assign busy     = status.full;
    assign push     = start && !status.full && known && in_range;

    assign push_cmd.op     = op;
    assign push_cmd.voice  = track;
    assign push_cmd.octave = octave;
    assign push_cmd.degree = degree;

endmodule

`default_nettype wire

FILE: sv/tnef_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses the command and status types of tnef_pkg.
`default_nettype none

module tnef_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tnef_pkg::note_cmd_t push_cmd,
    input  wire logic                pop,
    output tnef_pkg::note_cmd_t      pop_cmd,
    output tnef_pkg::queue_status_t  status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tnef_pkg::note_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;

endmodule

`default_nettype wire

FILE: sv/tnef_back.sv
// Back end: pops commands, emits the note-off, then for a note-on works out its frequency.
// One shared sequencer runs either the exp2 multiply chain or the restoring division.
// Uses tnef_pkg.
`default_nettype none

module tnef_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tnef_pkg::queue_status_t status,
    input  wire tnef_pkg::note_cmd_t     pop_cmd,
    output logic                         pop,
    output logic                         result_valid,
    output logic                         action,
    output logic [3:0]                   voice,
    output logic [tnef_pkg::FREQ_W-1:0]  frequency,
    output logic                         last
);

    localparam int MW = tnef_pkg::MANT_W;
    localparam int FW = tnef_pkg::FREQ_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [4:0]  LAST_STEP = 5'(tnef_pkg::STEPS - 1);
    localparam logic [MW:0] MANT_ONE  = (MW+1)'(1) << MW;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [4:0]    cnt_reg;
    logic [4:0]    cnt_next;
    logic [MW:0]   acc_reg;
    logic [MW:0]   acc_next;
    logic [MW-1:0] sh_reg;
    logic [MW-1:0] sh_next;
    logic [5:0]    rem_reg;
    logic [5:0]    rem_next;
    logic [6:0]    den_reg;
    logic [6:0]    den_next;
    logic [4:0]    exp_reg;
    logic [4:0]    exp_next;
    logic          is_ji_reg;
    logic          is_ji_next;
    logic [3:0]    voice_reg;
    logic [3:0]    voice_next;

    logic          valid_reg;
    logic          valid_next;
    logic          action_reg;
    logic          action_next;
    logic [3:0]    out_voice_reg;
    logic [3:0]    out_voice_next;
    logic [FW-1:0] freq_reg;
    logic [FW-1:0] freq_next;
    logic          last_reg;
    logic          last_next;

    logic [MW+1:0]   ratio;
    logic            q53;
    logic [5:0]      r53;
    logic [1:0]      q31;
    logic [5:0]      r31;
    logic [4:0]      exp_base;
    logic [4:0]      oct_p1;
    logic [12:0]     ji_scale;
    logic [6:0]      den7;
    logic [MW-1:0]   ji_num;
    logic [2*MW+1:0] prod;
    logic [6:0]      trial;
    logic            trial_ge;
    logic            edo_sat;
    logic [31:0]     round_sum;
    logic [31:0]     scaled;
    logic [FW-1:0]   edo_freq;

    always_comb
    begin
        ratio = tnef_pkg::ratio_lookup(pop_cmd.degree);

        q53 = pop_cmd.degree >= 6'd53;
        r53 = q53 ? pop_cmd.degree - 6'd53 : pop_cmd.degree;

        if (pop_cmd.degree >= 6'd62)
        begin
            q31 = 2'd2;
            r31 = pop_cmd.degree - 6'd62;
        end
        else if (pop_cmd.degree >= 6'd31)
        begin
            q31 = 2'd1;
            r31 = pop_cmd.degree - 6'd31;
        end
        else
        begin
            q31 = 2'd0;
            r31 = pop_cmd.degree;
        end

        exp_base = {1'b0, pop_cmd.octave} + 5'd3;
        oct_p1   = {1'b0, pop_cmd.octave} + 5'd1;
        ji_scale = {8'b0, oct_p1} * 13'd440;
        den7     = {1'b0, pop_cmd.degree} + 7'd1;
        ji_num   = {1'b0, ji_scale, 16'b0} + {24'b0, den7[6:1]};

        prod     = (2*MW+2)'(acc_reg) * (2*MW+2)'(tnef_pkg::EXP_ROOTS[cnt_reg]);
        trial    = {rem_reg, sh_reg[MW-1]};
        trial_ge = trial >= den_reg;

        edo_sat   = exp_reg >= 5'd14;
        round_sum = {1'b0, acc_reg} + (32'd1 << (4'd13 - exp_reg[3:0]));
        scaled    = round_sum >> (4'd14 - exp_reg[3:0]);
        edo_freq  = (edo_sat || scaled[31:30] != 2'b00) ? tnef_pkg::FREQ_MAX
                                                        : scaled[FW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        exp_next       = exp_reg;
        is_ji_next     = is_ji_reg;
        voice_next     = voice_reg;
        valid_next     = 1'b0;
        action_next    = action_reg;
        out_voice_next = out_voice_reg;
        freq_next      = freq_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!status.empty)
                begin
                    pop            = 1'b1;
                    valid_next     = 1'b1;
                    action_next    = tnef_pkg::ACT_OFF;
                    out_voice_next = pop_cmd.voice;
                    freq_next      = '0;
                    last_next      = pop_cmd.op == tnef_pkg::OP_OFF;
                    voice_next     = pop_cmd.voice;
                    cnt_next       = '0;
                    is_ji_next     = 1'b0;
                    unique case (pop_cmd.op)
                        tnef_pkg::OP_ON53:
                        begin
                            if (ratio[MW+1])
                            begin
                                acc_next   = ratio[MW:0];
                                exp_next   = exp_base;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                acc_next   = MANT_ONE;
                                sh_next    = tnef_pkg::FRAC53[r53];
                                exp_next   = exp_base + {4'b0, q53};
                                state_next = ST_CALC;
                            end
                        end
                        tnef_pkg::OP_ON31:
                        begin
                            acc_next   = MANT_ONE;
                            sh_next    = tnef_pkg::FRAC31[r31];
                            exp_next   = exp_base + {3'b0, q31};
                            state_next = ST_CALC;
                        end
                        tnef_pkg::OP_ONJI:
                        begin
                            is_ji_next = 1'b1;
                            sh_next    = ji_num;
                            rem_next   = '0;
                            den_next   = den7;
                            state_next = ST_CALC;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                if (is_ji_reg)
                begin
                    sh_next  = {sh_reg[MW-2:0], trial_ge};
                    rem_next = trial_ge ? 6'(trial - den_reg) : trial[5:0];
                end
                else
                begin
                    if (sh_reg[MW-1])
                    begin
                        acc_next = prod[2*MW:MW];
                    end
                    sh_next = {sh_reg[MW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                valid_next     = 1'b1;
                action_next    = tnef_pkg::ACT_ON;
                out_voice_next = voice_reg;
                freq_next      = is_ji_reg ? sh_reg : edo_freq;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sh_reg        <= sh_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        exp_reg       <= exp_next;
        is_ji_reg     <= is_ji_next;
        voice_reg     <= voice_next;
        action_reg    <= action_next;
        out_voice_reg <= out_voice_next;
        freq_reg      <= freq_next;
        last_reg      <= last_next;
    end

    assign result_valid = valid_reg;
    assign action       = action_reg;
    assign voice        = out_voice_reg;
    assign frequency    = freq_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: sv/tnef_checker.sv
// Port-level checks for the tuned note event to frequency block.
// Bound to the top level; needs no package.
`default_nettype none

module tnef_checker #(
    parameter int TRACKS = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        action,
    input wire logic [3:0]  voice,
    input wire logic [29:0] frequency,
    input wire logic        last
);

    localparam logic [6:0] TRACK_LIM = 7'(TRACKS);

    a_off_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !action |-> frequency == 30'd0)
        else $error("note-off item carries a nonzero frequency");

    a_on_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && action |-> last)
        else $error("note-on item is not the last of its event");

    a_on_after_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && action |-> !($past(result_valid) && $past(last)))
        else $error("note-on item directly follows a finished event");

    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> {3'b000, voice} < TRACK_LIM)
        else $error("item names a voice beyond the track count");

endmodule

bind tuned_note_event_to_frequency tnef_checker #(
    .TRACKS(TRACKS)
) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result_valid),
    .action      (action),
    .voice       (voice),
    .frequency   (frequency),
    .last        (last)
);

`default_nettype wire
